// ===== rtl/core/tsocc_pkg.sv =====
`default_nettype none

package tsocc_pkg;

    localparam int OBJECT_COUNT_DEF = 64;
    localparam int STAMP_BITS       = 16;
    localparam int MOMENT_BITS      = 12;
    localparam int INDEX_BITS       = 6;

    localparam logic [MOMENT_BITS-1:0] MOMENT_MAX = '1;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_CONFLICT = 2'd1;
    localparam logic [1:0] VERDICT_SKIPPED  = 2'd2;

    typedef struct packed {
        logic [1:0]            operation;
        logic [INDEX_BITS-1:0] object_index;
        logic [STAMP_BITS-1:0] transaction_stamp;
        logic                  first_in_schedule;
    } t_request;

    typedef struct packed {
        logic [1:0]             verdict;
        logic [MOMENT_BITS-1:0] moment;
    } t_result;

    // table view for the request in the check stage
    typedef struct packed {
        logic                  rd_valid;
        logic                  wr_valid;
        logic [STAMP_BITS-1:0] rd_stamp;
        logic [STAMP_BITS-1:0] wr_stamp;
    } t_lookup;

    typedef struct packed {
        logic                  clear;
        logic                  rd_wr;
        logic                  wr_wr;
        logic [STAMP_BITS-1:0] rd_stamp;
        logic [STAMP_BITS-1:0] wr_stamp;
    } t_update;

endpackage

`default_nettype wire

// ===== rtl/core/tsocc_ram.sv =====
`default_nettype none

module tsocc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsocc_table.sv =====
`default_nettype none

module tsocc_table #(
    parameter int OBJECT_COUNT = 64
) (
    input  wire logic                                               i_clk,
    input  wire logic                                               i_rst_n,
    input  wire logic [((OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1)-1:0] i_raddr,
    input  wire logic [((OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1)-1:0] i_addr,
    input  wire tsocc_pkg::t_update                                 i_upd,
    output tsocc_pkg::t_lookup                                      o_look
);
    import tsocc_pkg::*;

    localparam int IDX_W = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;

    logic [OBJECT_COUNT-1:0] r_rd_valid, n_rd_valid;
    logic [OBJECT_COUNT-1:0] r_wr_valid, n_wr_valid;
    logic [STAMP_BITS-1:0]   rd_q, wr_q;

    // last write of each RAM, covers the read that ran in parallel with it
    logic                  r_frd_v, r_fwr_v;
    logic [IDX_W-1:0]      r_frd_addr, r_fwr_addr;
    logic [STAMP_BITS-1:0] r_frd_data, r_fwr_data;

    tsocc_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(OBJECT_COUNT)
    ) u_rd_ram (
        .i_clk  (i_clk),
        .i_we   (i_upd.rd_wr),
        .i_waddr(i_addr),
        .i_wdata(i_upd.rd_stamp),
        .i_raddr(i_raddr),
        .o_rdata(rd_q)
    );

    tsocc_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(OBJECT_COUNT)
    ) u_wr_ram (
        .i_clk  (i_clk),
        .i_we   (i_upd.wr_wr),
        .i_waddr(i_addr),
        .i_wdata(i_upd.wr_stamp),
        .i_raddr(i_raddr),
        .o_rdata(wr_q)
    );

    // schedule clear is applied to the valid bits in the check stage
    always_comb begin
        o_look.rd_valid = r_rd_valid[i_addr];
        o_look.wr_valid = r_wr_valid[i_addr];
        o_look.rd_stamp = (r_frd_v && r_frd_addr == i_addr) ? r_frd_data : rd_q;
        o_look.wr_stamp = (r_fwr_v && r_fwr_addr == i_addr) ? r_fwr_data : wr_q;
    end

    always_comb begin
        n_rd_valid = i_upd.clear ? '0 : r_rd_valid;
        n_wr_valid = i_upd.clear ? '0 : r_wr_valid;
        if (i_upd.rd_wr) begin
            n_rd_valid[i_addr] = 1'b1;
        end
        if (i_upd.wr_wr) begin
            n_wr_valid[i_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= '0;
            r_wr_valid <= '0;
            r_frd_v    <= 1'b0;
            r_fwr_v    <= 1'b0;
        end else begin
            r_rd_valid <= n_rd_valid;
            r_wr_valid <= n_wr_valid;
            r_frd_v    <= i_upd.rd_wr;
            r_fwr_v    <= i_upd.wr_wr;
        end
        r_frd_addr <= i_addr;
        r_fwr_addr <= i_addr;
        r_frd_data <= i_upd.rd_stamp;
        r_fwr_data <= i_upd.wr_stamp;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsocc_check.sv =====
`default_nettype none

module tsocc_check #(
    parameter int OBJECT_COUNT = 64
) (
    input  wire logic                  i_valid,
    input  wire tsocc_pkg::t_request   i_req,
    input  wire logic                  i_rolled,
    input  wire tsocc_pkg::t_lookup    i_look,
    output tsocc_pkg::t_update         o_upd,
    output logic [1:0]                 o_verdict
);
    import tsocc_pkg::*;

    logic [STAMP_BITS-1:0] ts;
    logic                  in_range;
    logic                  w_newer, r_newer;
    logic                  clear;
    logic                  rd_v, wr_v;

    always_comb begin
        ts       = i_req.transaction_stamp[STAMP_BITS-1:0];
        in_range = int'(i_req.object_index) < OBJECT_COUNT;
        clear    = i_valid && i_req.first_in_schedule;
        rd_v     = i_look.rd_valid && !clear;
        wr_v     = i_look.wr_valid && !clear;
        w_newer  = wr_v && (i_look.wr_stamp > ts);
        r_newer  = rd_v && (i_look.rd_stamp > ts);

        o_verdict      = VERDICT_OK;
        o_upd.clear    = clear;
        o_upd.rd_wr    = 1'b0;
        o_upd.wr_wr    = 1'b0;
        o_upd.wr_stamp = ts;
        o_upd.rd_stamp = (!rd_v || i_look.rd_stamp < ts) ? ts : i_look.rd_stamp;

        if (i_rolled) begin
            o_verdict = VERDICT_SKIPPED;
        end else if (in_range) begin
            unique case (i_req.operation)
                OP_READ: begin
                    if (w_newer) begin
                        o_verdict = VERDICT_CONFLICT;
                    end else begin
                        o_upd.rd_wr = i_valid;
                    end
                end
                OP_WRITE: begin
                    if (w_newer || r_newer) begin
                        o_verdict = VERDICT_CONFLICT;
                    end else begin
                        o_upd.wr_wr = i_valid;
                    end
                end
                default: begin
                    // commit and the unused code write no stamp to the table
                    o_verdict = VERDICT_OK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/timestamp_order_conflict_checker_core.sv =====
`default_nettype none

// Timestamp-ordering conflict checker.
// Requests: one schedule operation (read, write or commit) with object index,
// transaction stamp and a first-of-schedule flag, taken when start is high
// and busy is low. busy stays low, so a request can be taken every cycle.
// Results: one per request, on o_result for a single cycle with o_strobe high.
// The verdict is ok, conflict (rollback latched here) or skipped; moment is
// the request's position in its schedule, saturating at its maximum.
// Pipeline: the request enters the input register as the stamp RAM is read,
// then it is checked and held in the result register, which raises o_strobe
// and presents o_result.
// Throughput: one request per cycle; the stamp RAM is read at accept and
// written from the check stage, and a one-entry forward covers back-to-back
// requests to the same object.
// Reset clears the valid bits, the rollback latch and the moment counter;
// stamps need no clearing since an invalid entry is never compared.
// The receiver cannot stall: each result is shown for exactly one cycle.

module timestamp_order_conflict_checker_core #(
    parameter int OBJECT_COUNT = tsocc_pkg::OBJECT_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire tsocc_pkg::t_request i_request,
    output logic                     busy,
    output logic                     o_strobe,
    output tsocc_pkg::t_result       o_result
);
    import tsocc_pkg::*;

    localparam int IDX_W = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;

    logic                   r_req_v;
    t_request               r_req;
    logic                   r_rolled, n_rolled;
    logic [MOMENT_BITS-1:0] r_moment, n_moment, here;
    logic                   rolled;
    logic [1:0]             verdict;
    t_lookup                look;
    t_update                upd;
    logic                   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    tsocc_table #(
        .OBJECT_COUNT(OBJECT_COUNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_raddr(IDX_W'(i_request.object_index)),
        .i_addr (IDX_W'(r_req.object_index)),
        .i_upd  (upd),
        .o_look (look)
    );

    tsocc_check #(
        .OBJECT_COUNT(OBJECT_COUNT)
    ) u_check (
        .i_valid  (r_req_v),
        .i_req    (r_req),
        .i_rolled (rolled),
        .i_look   (look),
        .o_upd    (upd),
        .o_verdict(verdict)
    );

    always_comb begin
        rolled   = r_req.first_in_schedule ? 1'b0 : r_rolled;
        here     = r_req.first_in_schedule ? '0 : r_moment;
        n_moment = (here < MOMENT_MAX) ? here + 1'b1 : here;
        n_rolled = rolled || (verdict == VERDICT_CONFLICT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v  <= 1'b0;
            r_rolled <= 1'b0;
            r_moment <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_req_v  <= accept;
            o_strobe <= r_req_v;
            if (r_req_v) begin
                r_rolled <= n_rolled;
                r_moment <= n_moment;
            end
        end
        if (accept) begin
            r_req <= i_request;
        end
        o_result.verdict <= verdict;
        o_result.moment  <= here;
    end

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("result strobe missing two cycles after request");

    a_first_moment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_request.first_in_schedule |=> ##1 (o_result.moment == '0))
        else $error("first request of schedule not at moment zero");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.verdict == VERDICT_OK ||
                      o_result.verdict == VERDICT_CONFLICT ||
                      o_result.verdict == VERDICT_SKIPPED))
        else $error("bad verdict code");

    a_rollback_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.verdict == VERDICT_CONFLICT ||
                     o_result.verdict == VERDICT_SKIPPED) |-> r_rolled)
        else $error("rollback latch clear after conflict or skip");

endmodule

`default_nettype wire
